// ----- rtl/cvam_pkg.sv -----
// Shared types, constants and arctangent table for the CORDIC angle/magnitude block.
package cvam_pkg;

   // Datapath widths: folded operands carry 38 bits after the guard shift
   localparam int XW          = 41;
   localparam int ZW          = 28;
   localparam int TW          = 30;
   localparam int AW          = 27;
   localparam int ANGLE_WIDTH = 25;
   localparam int ATAN_WIDTH  = 27;
   localparam int LO_WIDTH    = 20;
   localparam int HI_WIDTH    = XW - 1 - LO_WIDTH;
   localparam int GAIN_WIDTH  = 24;
   localparam int SW          = 66;

   // Gain 0.6072529 in Q24
   localparam logic [GAIN_WIDTH-1:0] GAIN_Q24 = 24'd10188013;

   // Angle constants, degrees
   localparam logic signed [TW-1:0] HALF_TURN_Q20 = 30'sd188743680;
   localparam logic signed [TW-1:0] FULL_TURN_Q20 = 30'sd377487360;
   localparam logic signed [TW-1:0] ANG_ROUND     = 30'sd8;
   localparam logic signed [AW-1:0] TURN_Q16      = 27'sd23592960;

   // atan(2^-i) in degrees, Q20
   localparam logic [ATAN_WIDTH-1:0] ATAN_TABLE [0:31] = '{
      27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121,
      27'd3750058,  27'd1876857,  27'd938658,   27'd469357,
      27'd234682,   27'd117342,   27'd58671,    27'd29335,
      27'd14668,    27'd7334,     27'd3667,     27'd1833,
      27'd917,      27'd458,      27'd229,      27'd115,
      27'd57,       27'd29,       27'd14,       27'd7,
      27'd4,        27'd2,        27'd1,        27'd0,
      27'd0,        27'd0,        27'd0,        27'd0
   };

   // How the input vector was folded into the first quadrant
   typedef enum logic [1:0] {
      FOLD_NONE,      // angle = a
      FOLD_MIRROR_X,  // angle = 180 - a
      FOLD_MIRROR_Y,  // angle = 360 - a
      FOLD_ROTATE     // angle = 180 + a
   } fold_type;

   // Control travelling alongside each pipeline stage
   typedef struct packed {
      logic     valid;
      fold_type fold;
      logic     axis;   // positive x axis or origin
   } ctrl_type;

endpackage

// ----- rtl/cvam_intf.sv -----
// Request and response channel interfaces for the CORDIC angle/magnitude block.
interface cvam_req_if #(parameter int DATA_WIDTH = 20);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] x_in;
   logic signed [DATA_WIDTH-1:0] y_in;

   modport source (output valid, x_in, y_in, input ready);
   modport sink   (input valid, x_in, y_in, output ready);
endinterface

interface cvam_rsp_if #(parameter int DATA_WIDTH = 20);
   logic                               valid;
   logic                               ready;
   logic [cvam_pkg::ANGLE_WIDTH-1:0]   angle_deg;
   logic [DATA_WIDTH-1:0]              magnitude;

   modport source (output valid, angle_deg, magnitude, input ready);
   modport sink   (input valid, angle_deg, magnitude, output ready);
endinterface

// ----- rtl/cordic_vector_angle_magnitude.sv -----
// Top level of the CORDIC vector angle and magnitude pipeline.
//
// Requests arrive on req_if (x_in, y_in, signed, same scale); each gives exactly
// one response on rsp_if: angle_deg in degrees with 16 fraction bits, 0 to below
// 360, and the rounded magnitude at the input scale, saturated to the field.
// Both channels move a request when valid and ready are high at a clock edge.
// The pipeline has one fold stage, one stage per micro-rotation, then
// partial-product, sum/round and output stages. A new request is taken in
// every cycle while the output is not stalled; throughput is one vector per cycle,
// set by the unrolled rotation chain with one adder stage per iteration.
// The whole pipeline advances together: while the response register holds an
// unaccepted result, req_if.ready is low and every stage holds its contents,
// so nothing is dropped or repeated. The response register is filled again in
// the cycle the receiver takes it.
// Synchronous reset clears all valid bits; nothing else needs clearing.
module cordic_vector_angle_magnitude #(
   parameter int ITERATIONS = 24,
   parameter int DATA_WIDTH = 20
) (
   input  logic       clock,
   input  logic       reset,
   cvam_req_if.sink   req_if,
   cvam_rsp_if.source rsp_if
);
   import cvam_pkg::*;

   logic                    advance;
   ctrl_type                ctrl_s     [ITERATIONS+1];
   logic signed [XW-1:0]    x_s        [ITERATIONS+1];
   logic signed [XW-1:0]    y_s        [ITERATIONS+1];
   logic signed [ZW-1:0]    z_s        [ITERATIONS+1];
   logic [DATA_WIDTH-1:0]   axis_mag_s [ITERATIONS+1];

   // Whole pipeline moves unless a result is waiting at the output
   assign advance      = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = advance;
   assign z_s[0]       = '0;

   cvam_fold #(.DATA_WIDTH(DATA_WIDTH)) u_fold (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .req_valid   (req_if.valid),
      .x           (req_if.x_in),
      .y           (req_if.y_in),
      .ctrl_ff     (ctrl_s[0]),
      .x_ff        (x_s[0]),
      .y_ff        (y_s[0]),
      .axis_mag_ff (axis_mag_s[0])
   );

   // Micro-rotation chain
   for (genvar g = 0; g < ITERATIONS; g++) begin : g_rot
      cvam_rotate #(.DATA_WIDTH(DATA_WIDTH), .STAGE(g)) u_rot (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .up_ctrl     (ctrl_s[g]),
         .up_x        (x_s[g]),
         .up_y        (y_s[g]),
         .up_z        (z_s[g]),
         .up_axis_mag (axis_mag_s[g]),
         .ctrl_ff     (ctrl_s[g+1]),
         .x_ff        (x_s[g+1]),
         .y_ff        (y_s[g+1]),
         .z_ff        (z_s[g+1]),
         .axis_mag_ff (axis_mag_s[g+1])
      );
   end

   cvam_finish #(.DATA_WIDTH(DATA_WIDTH)) u_finish (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .up_ctrl     (ctrl_s[ITERATIONS]),
      .up_x        (x_s[ITERATIONS]),
      .up_z        (z_s[ITERATIONS]),
      .up_axis_mag (axis_mag_s[ITERATIONS]),
      .valid_ff    (rsp_if.valid),
      .angle_ff    (rsp_if.angle_deg),
      .mag_ff      (rsp_if.magnitude)
   );

   // An accepted request lands in the fold stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> ctrl_s[0].valid)
      else $error("accepted request missing from fold stage");

   // A stalled pipeline holds the last rotation stage
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(x_s[ITERATIONS]) && $stable(z_s[ITERATIONS])
                   && ($stable(ctrl_s[ITERATIONS])))
      else $error("rotation chain moved during stall");

   // Angle stays within one turn
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.angle_deg < ANGLE_WIDTH'(TURN_Q16))
      else $error("angle outside 0 to 360");

endmodule

// ----- rtl/cvam_fold.sv -----
// Input stage: folds the request vector into the first quadrant and registers it.
module cvam_fold #(
   parameter int DATA_WIDTH = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             req_valid,
   input  logic signed [DATA_WIDTH-1:0]     x,
   input  logic signed [DATA_WIDTH-1:0]     y,
   output cvam_pkg::ctrl_type               ctrl_ff,
   output logic signed [cvam_pkg::XW-1:0]   x_ff,
   output logic signed [cvam_pkg::XW-1:0]   y_ff,
   output logic [DATA_WIDTH-1:0]            axis_mag_ff
);
   import cvam_pkg::*;

   localparam int GUARD = 38 - DATA_WIDTH;
   localparam int PAD   = XW - DATA_WIDTH - 1 - GUARD;

   logic signed [DATA_WIDTH:0] xe, ye;
   logic [DATA_WIDTH:0]        ax, ay;
   logic                       x_neg, y_zero, y_pos;
   ctrl_type                   ctrl_in;

   // Absolute values and quadrant decode
   always_comb begin
      xe      = {x[DATA_WIDTH-1], x};
      ye      = {y[DATA_WIDTH-1], y};
      x_neg   = x[DATA_WIDTH-1];
      y_zero  = (y == '0);
      y_pos   = !y[DATA_WIDTH-1] && !y_zero;
      ax      = x_neg ? unsigned'(-xe) : unsigned'(xe);
      ay      = y[DATA_WIDTH-1] ? unsigned'(-ye) : unsigned'(ye);
      ctrl_in.valid = req_valid;
      ctrl_in.axis  = !x_neg && y_zero;
      if (!x_neg && y_pos) begin
         ctrl_in.fold = FOLD_NONE;
      end else if (x_neg && y_pos) begin
         ctrl_in.fold = FOLD_MIRROR_X;
      end else if (!x_neg) begin
         ctrl_in.fold = FOLD_MIRROR_Y;
      end else begin
         ctrl_in.fold = FOLD_ROTATE;
      end
   end

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctrl_ff.fold <= ctrl_in.fold;
         ctrl_ff.axis <= ctrl_in.axis;
         x_ff         <= {{PAD{1'b0}}, ax, {GUARD{1'b0}}};
         y_ff         <= {{PAD{1'b0}}, ay, {GUARD{1'b0}}};
         axis_mag_ff  <= ax[DATA_WIDTH-1:0];
      end
   end

endmodule

// ----- rtl/cvam_rotate.sv -----
// One CORDIC vectoring micro-rotation, registered.
module cvam_rotate #(
   parameter int DATA_WIDTH = 20,
   parameter int STAGE      = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  cvam_pkg::ctrl_type               up_ctrl,
   input  logic signed [cvam_pkg::XW-1:0]   up_x,
   input  logic signed [cvam_pkg::XW-1:0]   up_y,
   input  logic signed [cvam_pkg::ZW-1:0]   up_z,
   input  logic [DATA_WIDTH-1:0]            up_axis_mag,
   output cvam_pkg::ctrl_type               ctrl_ff,
   output logic signed [cvam_pkg::XW-1:0]   x_ff,
   output logic signed [cvam_pkg::XW-1:0]   y_ff,
   output logic signed [cvam_pkg::ZW-1:0]   z_ff,
   output logic [DATA_WIDTH-1:0]            axis_mag_ff
);
   import cvam_pkg::*;

   localparam logic signed [ZW-1:0] STEP_ANGLE = {1'b0, ATAN_TABLE[STAGE]};

   logic signed [XW-1:0] dx, dy, x_in, y_in;
   logic signed [ZW-1:0] z_in;

   // Rotate towards the x axis; x stays positive so both shifts are arithmetic
   always_comb begin
      dx = up_y >>> STAGE;
      dy = up_x >>> STAGE;
      if (!up_y[XW-1]) begin
         x_in = up_x + dx;
         y_in = up_y - dy;
         z_in = up_z + STEP_ANGLE;
      end else begin
         x_in = up_x - dx;
         y_in = up_y + dy;
         z_in = up_z - STEP_ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctrl_ff.valid <= up_ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctrl_ff.fold <= up_ctrl.fold;
         ctrl_ff.axis <= up_ctrl.axis;
         x_ff         <= x_in;
         y_ff         <= y_in;
         z_ff         <= z_in;
         axis_mag_ff  <= up_axis_mag;
      end
   end

endmodule

// ----- rtl/cvam_finish.sv -----
// Output stages: gain multiply, quadrant unfold, rounding, wrap and saturation.
module cvam_finish #(
   parameter int DATA_WIDTH = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  cvam_pkg::ctrl_type                   up_ctrl,
   input  logic signed [cvam_pkg::XW-1:0]       up_x,
   input  logic signed [cvam_pkg::ZW-1:0]       up_z,
   input  logic [DATA_WIDTH-1:0]                up_axis_mag,
   output logic                                 valid_ff,
   output logic [cvam_pkg::ANGLE_WIDTH-1:0]     angle_ff,
   output logic [DATA_WIDTH-1:0]                mag_ff
);
   import cvam_pkg::*;

   localparam int GUARD = 38 - DATA_WIDTH;
   localparam int MW    = DATA_WIDTH + 2;
   localparam int PW    = LO_WIDTH + GAIN_WIDTH;
   localparam logic [SW-1:0] MAG_ROUND = SW'(1) << (23 + GUARD);

   // Stage A: partial products and unfolded angle
   logic                    a_valid_ff, a_axis_ff;
   logic [PW-1:0]           a_lo_ff, a_hi_ff;
   logic signed [TW-1:0]    a_total_ff, a_total_in, zx;
   logic [DATA_WIDTH-1:0]   a_axis_mag_ff;

   // Stage B: summed magnitude and rounded angle
   logic                    b_valid_ff, b_axis_ff;
   logic [MW-1:0]           b_mag_ff;
   logic signed [AW-1:0]    b_ang_ff;
   logic [DATA_WIDTH-1:0]   b_axis_mag_ff;
   logic [SW-1:0]           b_sum;
   logic signed [TW-1:0]    b_round;

   // Stage C: wrap and saturate
   logic signed [AW-1:0]    c_wrap;
   logic [ANGLE_WIDTH-1:0]  angle_in;
   logic [DATA_WIDTH-1:0]   mag_in;

   always_comb begin
      zx = TW'(up_z);
      case (up_ctrl.fold)
         FOLD_NONE:     a_total_in = zx;
         FOLD_MIRROR_X: a_total_in = HALF_TURN_Q20 - zx;
         FOLD_MIRROR_Y: a_total_in = FULL_TURN_Q20 - zx;
         FOLD_ROTATE:   a_total_in = HALF_TURN_Q20 + zx;
         default:       a_total_in = zx;
      endcase
   end

   always_comb begin
      b_sum   = {{(SW - PW - LO_WIDTH){1'b0}}, a_hi_ff, {LO_WIDTH{1'b0}}}
              + {{(SW - PW){1'b0}}, a_lo_ff} + MAG_ROUND;
      b_round = a_total_ff + ANG_ROUND;
   end

   always_comb begin
      if (b_ang_ff < 0) begin
         c_wrap = b_ang_ff + TURN_Q16;
      end else if (b_ang_ff >= TURN_Q16) begin
         c_wrap = b_ang_ff - TURN_Q16;
      end else begin
         c_wrap = b_ang_ff;
      end
      if (b_axis_ff || c_wrap < 0 || c_wrap >= TURN_Q16) begin
         angle_in = '0;
      end else begin
         angle_in = c_wrap[ANGLE_WIDTH-1:0];
      end
      if (b_axis_ff) begin
         mag_in = b_axis_mag_ff;
      end else if (|b_mag_ff[MW-1:DATA_WIDTH]) begin
         mag_in = '1;
      end else begin
         mag_in = b_mag_ff[DATA_WIDTH-1:0];
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= up_ctrl.valid;
         b_valid_ff <= a_valid_ff;
         valid_ff   <= b_valid_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         a_lo_ff       <= PW'(up_x[LO_WIDTH-1:0]) * PW'(GAIN_Q24);
         a_hi_ff       <= PW'(up_x[XW-2:LO_WIDTH]) * PW'(GAIN_Q24);
         a_total_ff    <= a_total_in;
         a_axis_ff     <= up_ctrl.axis;
         a_axis_mag_ff <= up_axis_mag;
         b_mag_ff      <= b_sum[24 + GUARD +: MW];
         // floor shift keeps the sign of a negative total
         b_ang_ff      <= {b_round[TW-1], b_round[TW-1:4]};
         b_axis_ff     <= a_axis_ff;
         b_axis_mag_ff <= a_axis_mag_ff;
         angle_ff      <= angle_in;
         mag_ff        <= mag_in;
      end
   end

endmodule
